### hdl/bbp_pkg.sv
// Shared types, constants and helpers of the block byte permuter.
// No dependencies; used by bbp_front, bbp_back and block_byte_permuter.
package bbp_pkg;

  localparam int LANE_BYTES    = 8;
  localparam int BLOCK_BYTES   = 256;
  localparam int NWORDS        = BLOCK_BYTES / LANE_BYTES;
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_BLOCK = 2'd2;
  localparam logic [1:0] OP_TAIL  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } bbp_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        last_of_run;
    logic        end_of_stream;
  } bbp_out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tidx;
    logic [7:0]  tval;
    logic [4:0]  waddr;
    logic [63:0] wdata;
    logic [7:0]  be;
    logic [7:0]  fill;
    logic        last;
  } bbp_cmd_t;

  function automatic logic [7:0] byte_mask(input logic [3:0] n);
    logic [7:0] m;
    for (int i = 0; i < LANE_BYTES; i++) begin
      m[i] = (4'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [63:0] expand_mask(input logic [7:0] be);
    logic [63:0] m;
    for (int i = 0; i < LANE_BYTES; i++) begin
      m[8*i +: 8] = {8{be[i]}};
    end
    return m;
  endfunction

endpackage

### hdl/bbp_fifo.sv
// Small first-in first-out queue of flip-flops with an occupancy count.
// Depends on nothing; used for the command queue and the result queue.
module bbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/bbp_front.sv
// Front end: accepts input items, tracks the block fill level and turns
// each item into one command. Depends on bbp_pkg.
module bbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  bbp_pkg::bbp_in_t   in_data,
  input  logic               cmd_full,
  output logic               cmd_push,
  output bbp_pkg::bbp_cmd_t  cmd
);
  import bbp_pkg::*;

  logic [7:0] fill_r, fill_nxt;
  logic [3:0] cnt_eff;
  logic [8:0] new_fill;
  logic [7:0] be;

  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    if (!in_data.last || in_data.byte_count > 4'(LANE_BYTES)) begin
      cnt_eff = 4'(LANE_BYTES);
    end else begin
      cnt_eff = in_data.byte_count;
    end
    new_fill = {1'b0, fill_r} + 9'(cnt_eff);
    be       = byte_mask(cnt_eff);

    cmd.tidx  = in_data.table_index;
    cmd.tval  = in_data.table_value;
    cmd.waddr = fill_r[7:3];
    cmd.wdata = in_data.data_word & expand_mask(be);
    cmd.be    = be;
    cmd.fill  = new_fill[7:0];
    cmd.last  = in_data.last;

    fill_nxt = fill_r;
    if (!in_data.kind) begin
      cmd.op = OP_LOAD;
    end else if (new_fill[8]) begin
      cmd.op   = OP_BLOCK;
      fill_nxt = '0;
    end else if (in_data.last) begin
      cmd.op   = OP_TAIL;
      fill_nxt = '0;
    end else begin
      cmd.op   = OP_STORE;
      fill_nxt = new_fill[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd_push) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

### hdl/bbp_back.sv
// Back end: owns the table, block buffer and scratch memories, runs the
// byte permutation pass and emits result words. Depends on bbp_pkg.
module bbp_back #(
  parameter int OUT_DEPTH = bbp_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rev,
  input  logic                           cmd_empty,
  input  bbp_pkg::bbp_cmd_t              cmd,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] res_count,
  output logic                           res_push,
  output bbp_pkg::bbp_out_t              res_data
);
  import bbp_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH+1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PERM = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [7:0]  tbl_mem [BLOCK_BYTES];
  logic [63:0] buf_mem [NWORDS];
  logic [63:0] scr_mem [NWORDS];

  logic [1:0]  state_r, state_nxt;
  logic [8:0]  z_r, z_nxt;
  logic [5:0]  w_r, w_nxt;
  logic [5:0]  nwords_r, nwords_nxt;
  logic [3:0]  last_n_r, last_n_nxt;
  logic        tail_r, tail_nxt;
  logic        eos_r, eos_nxt;

  logic        p1_v_r;
  logic [7:0]  p1_z_r;
  logic        p2_v_r;
  logic [7:0]  p2_dst_r;
  logic [2:0]  p2_lane_r;
  logic [7:0]  src;

  logic        rd_v_r;
  logic [4:0]  rd_w_r;
  logic [7:0]  rd_vld_r;
  logic [255:0] vld_r;

  logic [7:0]  tbl_rd_r;
  logic [63:0] buf_rd_r;
  logic [63:0] scr_rd_r;
  logic [4:0]  buf_ra;

  logic        perm_go, emit_go, blk_start;
  logic [8:0]  tail_sum;
  logic [OCW:0] occ;
  logic        is_end;
  logic [3:0]  nb;

  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
  assign blk_start = cmd_pop && (cmd.op == OP_BLOCK);
  assign perm_go   = (state_r == S_PERM) && !z_r[8];
  assign occ       = {1'b0, res_count} + (OCW+1)'(rd_v_r);
  assign emit_go   = (state_r == S_EMIT) && (w_r < nwords_r) && (occ < (OCW+1)'(OUT_DEPTH));
  assign src       = rev ? tbl_rd_r : p1_z_r;
  assign buf_ra    = (state_r == S_PERM) ? src[7:3] : w_r[4:0];
  assign tail_sum  = {1'b0, cmd.fill} + 9'd7;

  always_comb begin
    state_nxt  = state_r;
    z_nxt      = z_r;
    w_nxt      = w_r;
    nwords_nxt = nwords_r;
    last_n_nxt = last_n_r;
    tail_nxt   = tail_r;
    eos_nxt    = eos_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_pop && cmd.op == OP_BLOCK) begin
          state_nxt  = S_PERM;
          z_nxt      = '0;
          nwords_nxt = 6'(NWORDS);
          last_n_nxt = 4'(LANE_BYTES);
          tail_nxt   = 1'b0;
          eos_nxt    = cmd.last;
        end else if (cmd_pop && cmd.op == OP_TAIL && cmd.fill != '0) begin
          state_nxt  = S_EMIT;
          w_nxt      = '0;
          nwords_nxt = tail_sum[8:3];
          last_n_nxt = (cmd.fill[2:0] == '0) ? 4'(LANE_BYTES) : {1'b0, cmd.fill[2:0]};
          tail_nxt   = 1'b1;
          eos_nxt    = 1'b1;
        end
      end
      S_PERM: begin
        if (perm_go) begin
          z_nxt = z_r + 9'd1;
        end
        if (z_r[8] && !p1_v_r && !p2_v_r) begin
          state_nxt = S_EMIT;
          w_nxt     = '0;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          w_nxt = w_r + 6'd1;
        end
        if (w_r == nwords_r && !rd_v_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= perm_go;
      p2_v_r  <= p1_v_r;
      rd_v_r  <= emit_go;
    end
  end

  always_ff @(posedge clk) begin
    z_r       <= z_nxt;
    w_r       <= w_nxt;
    nwords_r  <= nwords_nxt;
    last_n_r  <= last_n_nxt;
    tail_r    <= tail_nxt;
    eos_r     <= eos_nxt;
    p1_z_r    <= z_r[7:0];
    p2_dst_r  <= rev ? p1_z_r : tbl_rd_r;
    p2_lane_r <= src[2:0];
    rd_w_r    <= w_r[4:0];
    rd_vld_r  <= vld_r[{w_r[4:0], 3'b000} +: 8];
    if (blk_start) begin
      vld_r <= '0;
    end else if (p2_v_r) begin
      vld_r[p2_dst_r] <= 1'b1;
    end
  end

  // table: written by load commands, read in index order by the pass
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_LOAD) begin
      tbl_mem[cmd.tidx] <= cmd.tval;
    end
    tbl_rd_r <= tbl_mem[z_r[7:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op != OP_LOAD) begin
      for (int b = 0; b < LANE_BYTES; b++) begin
        if (cmd.be[b]) begin
          buf_mem[cmd.waddr][8*b +: 8] <= cmd.wdata[8*b +: 8];
        end
      end
    end
    buf_rd_r <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk) begin
    if (p2_v_r) begin
      scr_mem[p2_dst_r[7:3]][8*p2_dst_r[2:0] +: 8] <= buf_rd_r[8*p2_lane_r +: 8];
    end
    scr_rd_r <= scr_mem[w_r[4:0]];
  end

  always_comb begin
    is_end   = ({1'b0, rd_w_r} == nwords_r - 6'd1);
    nb       = is_end ? last_n_r : 4'(LANE_BYTES);
    res_push = rd_v_r;
    if (tail_r) begin
      res_data.out_word = buf_rd_r & expand_mask(byte_mask(nb));
    end else begin
      res_data.out_word = scr_rd_r & expand_mask(rd_vld_r);
    end
    res_data.out_bytes     = nb;
    res_data.last_of_run   = is_end;
    res_data.end_of_stream = is_end && eos_r;
  end

endmodule

### hdl/block_byte_permuter.sv
// Top level of the block byte permuter: front end, command queue, back end
// and result queue. Depends on bbp_pkg, bbp_fifo, bbp_front and bbp_back.
//
// Permutes a byte stream in 256-byte blocks through a loaded 256-entry table.
// A table-load word and a data word that does not close a block are each
// written into the table or the block buffer when the back end takes them.
// A data word that completes a block is stored, then the permutation pass
// moves one byte per cycle through the table memory and the single read port
// of the block buffer, and then the 32 result words are read out. A last word
// that leaves a short tail is stored and its tail words are then read out of
// the block buffer. The command queue (CMD_DEPTH entries) lets input words
// be taken while the back end is busy; results wait in a queue of OUT_DEPTH
// entries. The cfg_wdata bit selects the inverse permutation and is read in
// the permutation pass. The table and buffer hold no reset value.
module block_byte_permuter #(
  parameter int CMD_DEPTH = bbp_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = bbp_pkg::OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bbp_pkg::bbp_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output bbp_pkg::bbp_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import bbp_pkg::*;

  localparam int CMD_W = $bits(bbp_cmd_t);
  localparam int OUT_W = $bits(bbp_out_t);

  logic                           rev_r;
  logic                           cmd_push, cmd_full, cmd_pop, cmd_empty;
  bbp_cmd_t                       cmd_in, cmd_out;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic                           res_push, oq_full;
  bbp_out_t                       res_data;
  logic [$clog2(OUT_DEPTH+1)-1:0] oq_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= 1'b0;
    end else if (cfg_we) begin
      rev_r <= cfg_wdata;
    end
  end

  assign in_full = cmd_full;

  bbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  bbp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  bbp_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rev       (rev_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (oq_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  bbp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty),
    .count (oq_count)
  );

`ifndef NO_ASSERTIONS
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full)
    else $error("result pushed into a full result queue");

  a_cmd_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_count != '0)
    else $error("command taken from an empty queue");

  a_eos_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.end_of_stream) |-> out_data.last_of_run)
    else $error("end of stream without end of run");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.out_bytes != 4'd0 && out_data.out_bytes <= 4'd8))
    else $error("result byte count out of range");
`endif

endmodule
